>>> sv/moving_average_window_defines.svh
`ifndef MOVING_AVERAGE_WINDOW_DEFINES_SVH
`define MOVING_AVERAGE_WINDOW_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MAW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MAW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/maw_pkg.sv
`default_nettype none

package maw_pkg;

  localparam int DEF_MAX_WINDOW   = 256;
  localparam int DEF_SAMPLE_WIDTH = 16;

  // window_size register and warm-up field
  localparam int SIZE_W = 9;
  localparam int WARM_W = 9;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd16;

  // in_tuser codes
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

>>> sv/maw_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle, signed dividend over a
// positive divisor, truncating toward zero. The quotient magnitude is known
// to fit SAMPLE_WIDTH bits, so the upper dividend bits preload the remainder.
module maw_div #(
  parameter int SAMPLE_WIDTH = maw_pkg::DEF_SAMPLE_WIDTH,
  parameter int SUM_W        = 24,
  parameter int CNT_W        = 9
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  input  wire  signed [SUM_W-1:0]       dividend,
  input  wire         [CNT_W-1:0]       divisor,
  output logic                          done,
  output logic signed [SAMPLE_WIDTH-1:0] quot
);

  `include "moving_average_window_defines.svh"

  localparam int ITER_W = $clog2(SAMPLE_WIDTH + 1);

  logic                    busy_r;
  logic [ITER_W-1:0]       iter_r;
  logic [CNT_W-1:0]        rem_r;
  logic [SAMPLE_WIDTH-1:0] lo_r;
  logic [SAMPLE_WIDTH-1:0] q_r;
  logic [CNT_W-1:0]        dvs_r;
  logic                    neg_r;
  logic                    done_r;
  logic signed [SAMPLE_WIDTH-1:0] quot_r;

  logic [SUM_W-1:0]        mag;
  logic [CNT_W:0]          trial;
  logic                    ge;
  logic [CNT_W-1:0]        rem_nxt;
  logic [SAMPLE_WIDTH-1:0] q_nxt;

  always_comb begin
    mag     = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
    trial   = {rem_r, lo_r[SAMPLE_WIDTH-1]};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? CNT_W'(trial - {1'b0, dvs_r}) : trial[CNT_W-1:0];
    q_nxt   = {q_r[SAMPLE_WIDTH-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        iter_r <= ITER_W'(SAMPLE_WIDTH);
      end else if (busy_r) begin
        iter_r <= iter_r - ITER_W'(1);
        if (iter_r == ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= CNT_W'(mag[SUM_W-1:SAMPLE_WIDTH]);
      lo_r  <= mag[SAMPLE_WIDTH-1:0];
      q_r   <= '0;
      dvs_r <= divisor;
      neg_r <= dividend[SUM_W-1];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      lo_r  <= {lo_r[SAMPLE_WIDTH-2:0], 1'b0};
      q_r   <= q_nxt;
      if (iter_r == ITER_W'(1)) begin
        quot_r <= neg_r ? SAMPLE_WIDTH'(-q_nxt) : q_nxt;
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

  `MAW_ASSERT_NOW(a_start_idle, start, !busy_r, "divider started while busy")
  `MAW_ASSERT_NEXT(a_done_pulse, done_r, !done_r && !busy_r, "divider done not a single pulse")

endmodule

`default_nettype wire

>>> sv/moving_average_window.sv
`default_nettype none

// Moving average over the last window_size samples.
// in_*  : one transaction per item. in_tuser = mode (clear when set),
//         in_tdata = signed sample (ignored on a clear).
// out_* : one transaction per item. out_tdata = {warmup_remaining, average},
//         average in the low SAMPLE_WIDTH bits.
// cfg_* : cfg_wr_en writes window_size and empties the window.
// A sample item passes through ST_UPD, ST_DIV_GO, ST_DIV_WAIT and ST_OUT
// before it shows on out_tvalid; the next item is taken once the result is
// in the output register. The shift-subtract divider gives one quotient bit a cycle.
// A clear item goes from ST_IDLE straight to ST_OUT, past the divider.
// Ring read and write go to a single-port memory in separate cycles.
// Reset: window_size = 16, sum, count and write pointer zero; ring contents
// are left as they are and never used before being written.
// A stalled out_tready holds the result in the output register; one more
// item is still taken and worked up to its result, then in_tready drops
// until the output register is free.
module moving_average_window #(
  parameter int MAX_WINDOW   = maw_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_WIDTH = maw_pkg::DEF_SAMPLE_WIDTH,
  localparam int IN_DW  = ((SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW = ((SAMPLE_WIDTH + maw_pkg::WARM_W + 7) / 8) * 8
) (
  input  wire                       clk,
  input  wire                       rst_n,
  // configuration
  input  wire                       cfg_wr_en,
  input  wire  [maw_pkg::SIZE_W-1:0] cfg_wr_data,   // window_size
  // input stream
  input  wire                       in_tvalid,
  output logic                      in_tready,
  input  wire  [IN_DW-1:0]          in_tdata,      // [SAMPLE_WIDTH-1:0] sample
  input  wire                       in_tuser,      // mode
  // result stream
  output logic                      out_tvalid,
  input  wire                       out_tready,
  output logic [OUT_DW-1:0]         out_tdata      // average, warmup_remaining
);

  `include "moving_average_window_defines.svh"

  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_WIDTH + PTR_W;
  localparam int EW    = (CNT_W > maw_pkg::SIZE_W) ? CNT_W : maw_pkg::SIZE_W;

  maw_pkg::state_t state_r, state_nxt;

  logic [maw_pkg::SIZE_W-1:0]    size_r;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt;
  logic [PTR_W-1:0]              pos_r, pos_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic signed [SAMPLE_WIDTH-1:0] samp_r;
  logic signed [SAMPLE_WIDTH-1:0] rd_data_r;
  logic signed [SAMPLE_WIDTH-1:0] res_avg_r;
  logic                          out_valid_r;
  logic [OUT_DW-1:0]             out_data_r;

  // ring of recent samples
  logic signed [SAMPLE_WIDTH-1:0] ring_mem [MAX_WINDOW];

  logic [EW-1:0]                 size_x, eff_x;
  logic [CNT_W-1:0]              eff;
  logic [PTR_W-1:0]              pos_use;
  logic [CNT_W-1:0]              pos_inc;
  logic                          full;
  logic                          in_acc;
  logic                          is_clear;
  logic                          ram_re, ram_we;
  logic                          div_start, div_done;
  logic signed [SAMPLE_WIDTH-1:0] div_quot;
  logic [maw_pkg::WARM_W-1:0]    warm;
  logic                          out_load;

  // effective window: zero acts as one, saturates at the ring depth
  always_comb begin
    size_x = EW'(size_r);
    if (size_x == '0) begin
      eff_x = EW'(1);
    end else if (size_x > EW'(MAX_WINDOW)) begin
      eff_x = EW'(MAX_WINDOW);
    end else begin
      eff_x = size_x;
    end
    eff = eff_x[CNT_W-1:0];
  end

  always_comb begin
    pos_use = (CNT_W'(pos_r) >= eff) ? '0 : pos_r;
    pos_inc = CNT_W'(pos_use) + CNT_W'(1);
    full    = (cnt_r >= eff);
    warm    = maw_pkg::WARM_W'(eff - cnt_r);
  end

  assign in_tready = (state_r == maw_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign is_clear  = (in_tuser == maw_pkg::MODE_CLEAR);
  assign ram_re    = in_acc && !is_clear;
  assign ram_we    = (state_r == maw_pkg::ST_UPD);
  assign div_start = (state_r == maw_pkg::ST_DIV_GO);
  assign out_load  = (state_r == maw_pkg::ST_OUT) && (!out_valid_r || out_tready);

  // next state and window update
  always_comb begin
    state_nxt = state_r;
    sum_nxt   = sum_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      maw_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (is_clear) begin
            sum_nxt   = '0;
            pos_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = maw_pkg::ST_OUT;
          end else begin
            state_nxt = maw_pkg::ST_UPD;
          end
        end
      end
      maw_pkg::ST_UPD: begin
        // oldest sample leaves only once the window is full
        sum_nxt   = sum_r - (full ? SUM_W'(rd_data_r) : '0) + SUM_W'(samp_r);
        pos_nxt   = (pos_inc >= eff) ? '0 : pos_inc[PTR_W-1:0];
        cnt_nxt   = full ? cnt_r : cnt_r + CNT_W'(1);
        state_nxt = maw_pkg::ST_DIV_GO;
      end
      maw_pkg::ST_DIV_GO: begin
        state_nxt = maw_pkg::ST_DIV_WAIT;
      end
      maw_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = maw_pkg::ST_OUT;
        end
      end
      maw_pkg::ST_OUT: begin
        if (out_load) begin
          state_nxt = maw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = maw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= maw_pkg::ST_IDLE;
      size_r      <= maw_pkg::SIZE_RESET;
      sum_r       <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        // a write always empties the window
        size_r <= cfg_wr_data;
        sum_r  <= '0;
        pos_r  <= '0;
        cnt_r  <= '0;
      end else begin
        sum_r <= sum_nxt;
        pos_r <= pos_nxt;
        cnt_r <= cnt_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      samp_r <= in_tdata[SAMPLE_WIDTH-1:0];
      if (is_clear) begin
        res_avg_r <= '0;
      end
    end
    if ((state_r == maw_pkg::ST_DIV_WAIT) && div_done) begin
      res_avg_r <= div_quot;
    end
    if (out_load) begin
      out_data_r <= OUT_DW'({warm, res_avg_r});
    end
  end

  // ring memory, registered read
  always_ff @(posedge clk) begin
    if (ram_we) begin
      ring_mem[pos_use] <= samp_r;
    end
    if (ram_re) begin
      rd_data_r <= ring_mem[pos_use];
    end
  end

  maw_div #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .SUM_W        (SUM_W),
    .CNT_W        (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `MAW_ASSERT_NOW(a_cnt_le_eff, 1'b1, cnt_r <= eff, "filled count above window size")
  `MAW_ASSERT_NOW(a_pos_lt_eff, 1'b1, CNT_W'(pos_r) < eff, "write pointer outside window")
  `MAW_ASSERT_NOW(a_done_in_wait, div_done, state_r == maw_pkg::ST_DIV_WAIT, "stray divider result")
  `MAW_ASSERT_NEXT(a_sample_upd, in_acc && !is_clear, state_r == maw_pkg::ST_UPD, "sample not updated")

endmodule

`default_nettype wire
